@@ design/sle_pkg.sv @@
package sle_pkg;

  // Store geometry.
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMD_BITS   = 3;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  // Command codes carried in the command field.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // Status codes returned with every result word.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  // One result word as held inside the block.
  typedef struct packed {
    status_e status;
    addr_t   where_found;
    value_t  read_value;
    count_t  entry_count;
  } result_t;

endpackage

@@ design/sle_if.sv @@
// Command channel: one word per command.
interface sle_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [sle_pkg::CMD_BITS-1:0]     command;
  logic signed [sle_pkg::VALUE_BITS-1:0] value;
  logic [sle_pkg::ADDR_BITS-1:0]    read_position;

  modport source (output valid, command, value, read_position, input ready);
  modport sink   (input valid, command, value, read_position, output ready);
endinterface

// Result channel: one word per command.
interface sle_res_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [sle_pkg::ADDR_BITS-1:0]    where_found;
  logic signed [sle_pkg::VALUE_BITS-1:0] read_value;
  logic [sle_pkg::COUNT_BITS-1:0]   entry_count;

  modport source (output valid, status, where_found, read_value, entry_count, input ready);
  modport sink   (input valid, status, where_found, read_value, entry_count, output ready);
endinterface

@@ design/sorted_list_engine.sv @@
// Sorted list engine: an ordered store of signed values in one RAM.
// A full push or insert, a bad read position and unused codes skip the walk and go straight
// to the finish state; read walks the one entry asked for; the others run a walk that
// passes the RAM read port over each stored entry at most once.
// One command at a time; the next word can be taken in the same cycle as the result shows.
// Reset clears count and control state, not the RAM contents.
module sorted_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_cmd_if.sink   cmd_i,
  sle_res_if.source res_o
);

  sle_pkg::state_e  state_q, state_d;
  logic [sle_pkg::CMD_BITS-1:0] cmd_q, cmd_d;
  sle_pkg::value_t  val_q, val_d;
  sle_pkg::value_t  carry_q, carry_d;
  sle_pkg::count_t  cnt_q, cnt_d;
  sle_pkg::count_t  rd_idx_q, rd_idx_d;
  sle_pkg::count_t  lim_q, lim_d;
  logic             rd_pend_q, rd_pend_d;
  sle_pkg::addr_t   dat_idx_q, dat_idx_d;
  logic             found_q, found_d;
  sle_pkg::addr_t   pos_q, pos_d;
  sle_pkg::result_t res_q, res_d;
  sle_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             ram_we;
  sle_pkg::addr_t   ram_waddr;
  sle_pkg::value_t  ram_wdata;
  logic             ram_re;
  sle_pkg::value_t  ram_rdata;
  logic             walk_end;

  sle_ram #(
    .DEPTH (sle_pkg::CAPACITY),
    .WIDTH (sle_pkg::VALUE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[sle_pkg::ADDR_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign cmd_i.ready = (state_q == sle_pkg::S_IDLE);
  assign ram_re      = (state_q == sle_pkg::S_WALK) && (rd_idx_q < lim_q);
  assign walk_end    = !rd_pend_q && (rd_idx_q >= lim_q);

  // Sequencer: accept a command, walk the store where the command needs it, then hand the result on.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    carry_d     = carry_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    lim_d       = lim_q;
    rd_pend_d   = rd_pend_q;
    dat_idx_d   = dat_idx_q;
    found_d     = found_q;
    pos_d       = pos_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = dat_idx_q;
    ram_wdata   = carry_q;

    unique case (state_q)
      sle_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d     = cmd_i.command;
          val_d     = cmd_i.value;
          carry_d   = cmd_i.value;
          rd_idx_d  = '0;
          lim_d     = cnt_q;
          rd_pend_d = 1'b0;
          found_d   = (cmd_i.command == sle_pkg::CMD_PUSH);
          pos_d     = '0;
          res_d.status      = sle_pkg::ST_OK;
          res_d.where_found = '0;
          res_d.read_value  = '0;
          res_d.entry_count = cnt_q;
          unique case (cmd_i.command)
            sle_pkg::CMD_PUSH, sle_pkg::CMD_INSERT: begin
              if (cnt_q == sle_pkg::COUNT_BITS'(sle_pkg::CAPACITY)) begin
                res_d.status = sle_pkg::ST_FULL;
                state_d      = sle_pkg::S_FINISH;
              end else begin
                state_d = sle_pkg::S_WALK;
              end
            end
            sle_pkg::CMD_DELETE, sle_pkg::CMD_SEARCH: begin
              state_d = sle_pkg::S_WALK;
            end
            sle_pkg::CMD_READ: begin
              if (sle_pkg::COUNT_BITS'(cmd_i.read_position) >= cnt_q) begin
                res_d.status = sle_pkg::ST_BEYOND;
                state_d      = sle_pkg::S_FINISH;
              end else begin
                rd_idx_d = sle_pkg::COUNT_BITS'(cmd_i.read_position);
                lim_d    = sle_pkg::COUNT_BITS'(cmd_i.read_position)
                           + sle_pkg::COUNT_BITS'(1);
                state_d  = sle_pkg::S_WALK;
              end
            end
            default: begin
              state_d = sle_pkg::S_FINISH;
            end
          endcase
        end
      end

      sle_pkg::S_WALK: begin
        // Issue the next read of the walk.
        if (ram_re) begin
          rd_idx_d  = rd_idx_q + sle_pkg::COUNT_BITS'(1);
          dat_idx_d = rd_idx_q[sle_pkg::ADDR_BITS-1:0];
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end

        // Act on the entry read in the previous cycle.
        if (rd_pend_q) begin
          unique case (cmd_q)
            sle_pkg::CMD_PUSH, sle_pkg::CMD_INSERT: begin
              // From the insert point on, each entry moves up by one place.
              if (found_q || (ram_rdata > val_q)) begin
                ram_we    = 1'b1;
                ram_waddr = dat_idx_q;
                ram_wdata = carry_q;
                carry_d   = ram_rdata;
                if (!found_q) begin
                  found_d = 1'b1;
                  pos_d   = dat_idx_q;
                end
              end
            end
            sle_pkg::CMD_DELETE: begin
              // Past the match, each entry moves down by one place.
              if (found_q) begin
                ram_we    = 1'b1;
                ram_waddr = dat_idx_q - sle_pkg::ADDR_BITS'(1);
                ram_wdata = ram_rdata;
              end else if (ram_rdata == val_q) begin
                found_d = 1'b1;
                pos_d   = dat_idx_q;
              end
            end
            sle_pkg::CMD_SEARCH: begin
              if (ram_rdata == val_q) begin
                res_d.where_found = dat_idx_q;
                res_d.read_value  = ram_rdata;
                state_d           = sle_pkg::S_FINISH;
              end
            end
            sle_pkg::CMD_READ: begin
              res_d.where_found = dat_idx_q;
              res_d.read_value  = ram_rdata;
              state_d           = sle_pkg::S_FINISH;
            end
            default: begin
            end
          endcase
        end

        // Close the walk once every entry has been seen.
        if (walk_end) begin
          state_d = sle_pkg::S_FINISH;
          unique case (cmd_q)
            sle_pkg::CMD_PUSH, sle_pkg::CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[sle_pkg::ADDR_BITS-1:0];
              ram_wdata = carry_q;
              cnt_d     = cnt_q + sle_pkg::COUNT_BITS'(1);
              res_d.where_found = found_q ? pos_q : cnt_q[sle_pkg::ADDR_BITS-1:0];
              res_d.entry_count = cnt_q + sle_pkg::COUNT_BITS'(1);
            end
            sle_pkg::CMD_DELETE: begin
              if (found_q) begin
                cnt_d             = cnt_q - sle_pkg::COUNT_BITS'(1);
                res_d.where_found = pos_q;
                res_d.entry_count = cnt_q - sle_pkg::COUNT_BITS'(1);
              end else begin
                res_d.status = sle_pkg::ST_NOT_FOUND;
              end
            end
            sle_pkg::CMD_SEARCH: begin
              res_d.status = sle_pkg::ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end
      end

      sle_pkg::S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = sle_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sle_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sle_pkg::S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      lim_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      lim_q       <= lim_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    carry_q   <= carry_d;
    dat_idx_q <= dat_idx_d;
    pos_q     <= pos_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Result channel.
  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_q.status;
  assign res_o.where_found = out_q.where_found;
  assign res_o.read_value  = out_q.read_value;
  assign res_o.entry_count = out_q.entry_count;

endmodule

@@ design/sle_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents.
module sle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sle_checker.sv @@
// Port-level checks on the result channel of the sorted list engine.
module sle_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic [1:0]                        status_i,
  input logic [sle_pkg::ADDR_BITS-1:0]     where_i,
  input logic signed [sle_pkg::VALUE_BITS-1:0] rval_i,
  input logic [sle_pkg::COUNT_BITS-1:0]    count_i
);

  // A result word stays offered until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped before it was taken");

  // The count never exceeds the store size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> count_i <= sle_pkg::COUNT_BITS'(sle_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // A failed command reports neither a position nor a value.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i != sle_pkg::ST_OK) |-> (where_i == '0) && (rval_i == '0))
    else $error("failed command carries position or value");

  // A full status is only given when the store is full.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == sle_pkg::ST_FULL)
      |-> count_i == sle_pkg::COUNT_BITS'(sle_pkg::CAPACITY))
    else $error("full status with room left");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .where_i     (res_o.where_found),
  .rval_i      (res_o.read_value),
  .count_i     (res_o.entry_count)
);
